### rtl/srcrc_pkg.sv
// shared types, constants and crc helpers for the sensor readout checker
`timescale 1ns / 1ps
package srcrc_pkg;

   localparam int unsigned CRC_BITS     = 7;
   localparam int unsigned PAYLOAD_BITS = 17;
   localparam int unsigned VALUE_BITS   = 16;
   localparam int unsigned WORD_BITS    = PAYLOAD_BITS + CRC_BITS;
   // bits of the word left after the head of the division
   localparam int unsigned TAIL_BITS    = 15;
   localparam int unsigned HEAD_STEPS   = 9;
   localparam int unsigned TAIL_STEPS   = PAYLOAD_BITS - HEAD_STEPS;

   localparam logic [CRC_BITS:0]   CRC_POLY = 8'h89;
   localparam logic [CRC_BITS-1:0] CRC_INIT = 7'h7F;

   typedef enum logic [1:0] {
      STATUS_PASS      = 2'd0,
      STATUS_CRC_ERR   = 2'd1,
      STATUS_NOT_VALID = 2'd2
   } status_type;

   // pipeline advance strobes handed to every lane
   typedef struct packed {
      logic s1;
      logic s2;
   } pipe_en_type;

   // what one lane reports after its crc check
   typedef struct packed {
      logic                  valid_flag;
      logic                  crc_ok;
      logic [VALUE_BITS-1:0] value;
   } lane_result_type;

   // first nine division steps over {valid, value, init}
   function automatic logic [TAIL_BITS-1:0] crc_head(input logic [WORD_BITS-1:0] word);
      logic [WORD_BITS-1:0] w;
      w = word;
      for (int i = 0; i < HEAD_STEPS; i++) begin
         if (w[WORD_BITS-1-i]) begin
            w = w ^ (WORD_BITS'(CRC_POLY) << (PAYLOAD_BITS - 1 - i));
         end
      end
      return w[TAIL_BITS-1:0];
   endfunction

   // remaining eight steps, leaves the 7-bit remainder
   function automatic logic [CRC_BITS-1:0] crc_tail(input logic [TAIL_BITS-1:0] part);
      logic [TAIL_BITS-1:0] w;
      w = part;
      for (int j = 0; j < TAIL_STEPS; j++) begin
         if (w[TAIL_BITS-1-j]) begin
            w = w ^ (TAIL_BITS'(CRC_POLY) << (TAIL_STEPS - 1 - j));
         end
      end
      return w[CRC_BITS-1:0];
   endfunction

endpackage

### rtl/srcrc_req_if.sv
// request channel carrying the six readout bytes
`timescale 1ns / 1ps
interface srcrc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] temp_low_byte;
   logic [7:0] temp_high_byte;
   logic [7:0] temp_check_byte;
   logic [7:0] humid_low_byte;
   logic [7:0] humid_high_byte;
   logic [7:0] humid_check_byte;

   modport source (
      output valid, temp_low_byte, temp_high_byte, temp_check_byte,
             humid_low_byte, humid_high_byte, humid_check_byte,
      input  ready
   );
   modport sink (
      input  valid, temp_low_byte, temp_high_byte, temp_check_byte,
             humid_low_byte, humid_high_byte, humid_check_byte,
      output ready
   );
endinterface

### rtl/srcrc_rsp_if.sv
// response channel carrying status and corrected readings
`timescale 1ns / 1ps
interface srcrc_rsp_if;
   logic               valid;
   logic               ready;
   logic [1:0]         status;
   logic signed [16:0] temperature;
   logic [15:0]        humidity;

   modport source (
      output valid, status, temperature, humidity,
      input  ready
   );
   modport sink (
      input  valid, status, temperature, humidity,
      output ready
   );
endinterface

### rtl/sensor_readout_crc7_checker_top.sv
// top level of the sensor readout crc-7 checker
//
// checks one six-byte sensor readout per request: a temperature word and a
// humidity word, each a little-endian 16-bit value plus a check byte holding
// a valid flag (bit 0) and a crc-7 (bits 7:1, poly 0x89, init all ones)
// req_chan: request with the six bytes, taken when valid and ready are high
// rsp_chan: status (ok, crc error, not valid) with temperature minus the
//   solder correction and raw humidity; both readings zero unless ok
// csr_wr_en / csr_wr_data: writes the 8-bit solder correction, write only
// two crc lanes run side by side, each splitting its 17 division steps over
// two register stages, then a merge stage registers the response
// path: an accepted request is registered by lane stage s1, then lane stage s2,
//   then the merge stage, whose registers drive the response
// throughput: one request per cycle unless the receiver stalls; each stage holds one request
// a stalled receiver freezes the stages from the back; a bubble further up
// still moves forward, and ready drops only once every stage is full
// reset: empties the pipeline and sets the solder correction to zero
`timescale 1ns / 1ps
module sensor_readout_crc7_checker_top (
   input  logic        clock,
   input  logic        reset,
   srcrc_req_if.sink   req_chan,
   srcrc_rsp_if.source rsp_chan,
   input  logic        csr_wr_en,
   input  logic [7:0]  csr_wr_data
);

   // per-stage occupancy of the pipeline
   logic v1_ff, v1_in;
   logic v2_ff, v2_in;
   logic v3_ff, v3_in;

   // solder correction register
   logic [7:0] corr_ff, corr_in;

   srcrc_pkg::pipe_en_type     pipe_en;
   logic                       en3;
   srcrc_pkg::lane_result_type temp_res;
   srcrc_pkg::lane_result_type humid_res;

   // a stage loads when it is empty or its contents move on
   always_comb begin
      en3        = !v3_ff || rsp_chan.ready;
      pipe_en.s2 = !v2_ff || en3;
      pipe_en.s1 = !v1_ff || pipe_en.s2;

      v1_in = pipe_en.s1 ? req_chan.valid : v1_ff;
      v2_in = pipe_en.s2 ? v1_ff : v2_ff;
      v3_in = en3 ? v2_ff : v3_ff;

      corr_in = csr_wr_en ? csr_wr_data : corr_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff   <= 1'b0;
         v2_ff   <= 1'b0;
         v3_ff   <= 1'b0;
         corr_ff <= '0;
      end else begin
         v1_ff   <= v1_in;
         v2_ff   <= v2_in;
         v3_ff   <= v3_in;
         corr_ff <= corr_in;
      end
   end

   assign req_chan.ready = pipe_en.s1;
   assign rsp_chan.valid = v3_ff;

   // temperature word lane
   srcrc_lane u_temp_lane (
      .clock      (clock),
      .pipe_en    (pipe_en),
      .low_byte   (req_chan.temp_low_byte),
      .high_byte  (req_chan.temp_high_byte),
      .check_byte (req_chan.temp_check_byte),
      .result     (temp_res)
   );

   // humidity word lane
   srcrc_lane u_humid_lane (
      .clock      (clock),
      .pipe_en    (pipe_en),
      .low_byte   (req_chan.humid_low_byte),
      .high_byte  (req_chan.humid_high_byte),
      .check_byte (req_chan.humid_check_byte),
      .result     (humid_res)
   );

   // crc errors win over a clear valid flag
   srcrc_merge u_merge (
      .clock             (clock),
      .enable            (en3),
      .solder_correction (corr_ff),
      .temp_lane         (temp_res),
      .humid_lane        (humid_res),
      .status            (rsp_chan.status),
      .temperature       (rsp_chan.temperature),
      .humidity          (rsp_chan.humidity)
   );

endmodule

### rtl/srcrc_lane.sv
// one crc-7 check lane: split division over two register stages
`timescale 1ns / 1ps
module srcrc_lane (
   input  logic                         clock,
   input  srcrc_pkg::pipe_en_type       pipe_en,
   input  logic [7:0]                   low_byte,
   input  logic [7:0]                   high_byte,
   input  logic [7:0]                   check_byte,
   output srcrc_pkg::lane_result_type   result
);

   logic [srcrc_pkg::TAIL_BITS-1:0]  part_ff,  part_in;
   logic [srcrc_pkg::VALUE_BITS-1:0] value_ff, value_in;
   logic                             flag_ff,  flag_in;
   logic [srcrc_pkg::CRC_BITS-1:0]   rcvd_ff,  rcvd_in;
   srcrc_pkg::lane_result_type       res_ff,   res_in;

   always_comb begin
      value_in = {high_byte, low_byte};
      flag_in  = check_byte[0];
      rcvd_in  = check_byte[7:1];
      part_in  = srcrc_pkg::crc_head({check_byte[0], high_byte, low_byte,
                                      srcrc_pkg::CRC_INIT});

      res_in.valid_flag = flag_ff;
      res_in.value      = value_ff;
      res_in.crc_ok     = (srcrc_pkg::crc_tail(part_ff) == rcvd_ff);
   end

   always_ff @(posedge clock) begin
      if (pipe_en.s1) begin
         part_ff  <= part_in;
         value_ff <= value_in;
         flag_ff  <= flag_in;
         rcvd_ff  <= rcvd_in;
      end
      if (pipe_en.s2) begin
         res_ff <= res_in;
      end
   end

   assign result = res_ff;

endmodule

### rtl/srcrc_merge.sv
// merges both lane verdicts into status and corrected readings
`timescale 1ns / 1ps
module srcrc_merge (
   input  logic                        clock,
   input  logic                        enable,
   input  logic [7:0]                  solder_correction,
   input  srcrc_pkg::lane_result_type  temp_lane,
   input  srcrc_pkg::lane_result_type  humid_lane,
   output logic [1:0]                  status,
   output logic signed [16:0]          temperature,
   output logic [15:0]                 humidity
);

   srcrc_pkg::status_type status_ff, status_in;
   logic signed [16:0]    temp_ff,   temp_in;
   logic [15:0]           humid_ff,  humid_in;

   always_comb begin
      status_in = srcrc_pkg::STATUS_PASS;
      temp_in   = '0;
      humid_in  = '0;
      if (!temp_lane.crc_ok || !humid_lane.crc_ok) begin
         status_in = srcrc_pkg::STATUS_CRC_ERR;
      end else if (!temp_lane.valid_flag || !humid_lane.valid_flag) begin
         status_in = srcrc_pkg::STATUS_NOT_VALID;
      end else begin
         temp_in  = signed'({1'b0, temp_lane.value} - {9'd0, solder_correction});
         humid_in = humid_lane.value;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         status_ff <= status_in;
         temp_ff   <= temp_in;
         humid_ff  <= humid_in;
      end
   end

   assign status      = status_ff;
   assign temperature = temp_ff;
   assign humidity    = humid_ff;

endmodule

### dv/sensor_readout_crc7_checker_top_test.sv
// self-checking testbench for the sensor readout crc-7 checker top level
`timescale 1ns / 1ps
module sensor_readout_crc7_checker_top_test;

   // run shape
   localparam int unsigned PHASES           = 5;
   localparam int unsigned PHASE_READOUTS   = 190;   // five phases, about 950 requests
   localparam int unsigned MAX_GAP          = 4;     // per-request idle on either side
   localparam int unsigned SETTLE_CYCLES    = 6;     // longer than the request-to-response latency
   localparam int unsigned LONG_HOLD_AT     = 600;   // responses seen before the long stall
   localparam int unsigned LONG_HOLD_CYCLES = 80;    // long enough to fill every stage
   localparam int unsigned TIMEOUT_NS       = 2000000;
   // flips the lowest crc bit of a check byte (bit 0 is the valid flag)
   localparam logic [7:0]  CRC_LSB_FLIP     = 8'h02;

   // the six readout bytes of one request
   typedef struct packed {
      logic [7:0] t_lo;
      logic [7:0] t_hi;
      logic [7:0] t_chk;
      logic [7:0] h_lo;
      logic [7:0] h_hi;
      logic [7:0] h_chk;
   } readout_type;

   // one checked reading as the block reports it
   typedef struct packed {
      srcrc_pkg::status_type status;
      logic signed [16:0]    temperature;
      logic [15:0]           humidity;
   } reading_type;

   // how a directed row builds its check bytes
   typedef enum {
      FORM_SEALED,          // good crc over the flag in bit 0 of the check column
      FORM_TEMP_CRC_BAD,    // sealed, then the temperature crc is broken
      FORM_HUMID_CRC_BAD,   // sealed, then the humidity crc is broken
      FORM_RAW              // check bytes used exactly as written
   } row_form_type;

   typedef struct {
      logic [7:0]   corr;
      logic [15:0]  temp;
      logic [15:0]  humid;
      logic [7:0]   t_chk;
      logic [7:0]   h_chk;
      row_form_type form;
      bit           typed;   // lit holds the expected reading
      reading_type  lit;
   } directed_row_type;

   logic clock;
   logic reset = 1'b1;
   logic csr_wr_en;
   logic [7:0] csr_wr_data;

   srcrc_req_if req_bus ();
   srcrc_rsp_if rsp_bus ();

   sensor_readout_crc7_checker_top uut (
      .clock       (clock),
      .reset       (reset),
      .req_chan    (req_bus),
      .rsp_chan    (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // shadow of the solder correction register
   logic [7:0]  solder_corr = 8'd0;
   // readings still owed by the block, oldest first
   reading_type expected_readings [$];
   // zero idle on both sides while set
   bit          idle_off = 1'b0;
   int unsigned mismatches = 0;
   int unsigned responses_seen = 0;
   int unsigned ok_seen = 0;
   int unsigned crc_err_seen = 0;
   int unsigned invalid_seen = 0;
   int unsigned settings_used = 1;

   // directed requests: extremes, both error kinds, their precedence, and
   // the negative range of the corrected temperature
   directed_row_type directed_rows [0:18] = '{
      // reset correction of zero, smallest and largest values
      '{8'd0, 16'h0000, 16'h0000, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0000}},
      '{8'd0, 16'hFFFF, 16'hFFFF, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, 17'sd65535, 16'hFFFF}},
      '{8'd0, 16'h1234, 16'hABCD, 8'h01, 8'h01, FORM_SEALED, 1'b0,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0000}},
      // one or both valid flags clear, crc good
      '{8'd0, 16'h0F0F, 16'hF0F0, 8'h00, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_NOT_VALID, 17'sd0, 16'h0000}},
      '{8'd0, 16'h0F0F, 16'hF0F0, 8'h01, 8'h00, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_NOT_VALID, 17'sd0, 16'h0000}},
      '{8'd0, 16'hFFFF, 16'hFFFF, 8'h00, 8'h00, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_NOT_VALID, 17'sd0, 16'h0000}},
      // a bad crc in either word
      '{8'd0, 16'h4321, 16'h8765, 8'h01, 8'h01, FORM_TEMP_CRC_BAD, 1'b1,
        '{srcrc_pkg::STATUS_CRC_ERR, 17'sd0, 16'h0000}},
      '{8'd0, 16'h4321, 16'h8765, 8'h01, 8'h01, FORM_HUMID_CRC_BAD, 1'b1,
        '{srcrc_pkg::STATUS_CRC_ERR, 17'sd0, 16'h0000}},
      // crc error wins over a clear valid flag
      '{8'd0, 16'h0001, 16'h0002, 8'h00, 8'h00, FORM_TEMP_CRC_BAD, 1'b1,
        '{srcrc_pkg::STATUS_CRC_ERR, 17'sd0, 16'h0000}},
      '{8'd0, 16'h8000, 16'h0001, 8'h00, 8'h01, FORM_HUMID_CRC_BAD, 1'b1,
        '{srcrc_pkg::STATUS_CRC_ERR, 17'sd0, 16'h0000}},
      // raw check bytes, whatever they decode to
      '{8'd0, 16'h0000, 16'h0000, 8'h00, 8'h00, FORM_RAW, 1'b0,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0000}},
      '{8'd0, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, FORM_RAW, 1'b0,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0000}},
      '{8'd0, 16'h5555, 16'hAAAA, 8'hFE, 8'hFE, FORM_RAW, 1'b0,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0000}},
      // largest correction, temperature goes negative
      '{8'd255, 16'h0000, 16'h0000, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, -17'sd255, 16'h0000}},
      '{8'd255, 16'h00FF, 16'h0001, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0001}},
      '{8'd255, 16'h00FE, 16'h8000, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, -17'sd1, 16'h8000}},
      '{8'd255, 16'hFFFF, 16'hFFFF, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, 17'sd65280, 16'hFFFF}},
      // smallest nonzero correction
      '{8'd1, 16'h0000, 16'h7FFF, 8'h01, 8'h01, FORM_SEALED, 1'b1,
        '{srcrc_pkg::STATUS_PASS, -17'sd1, 16'h7FFF}},
      '{8'd1, 16'h8001, 16'h00FF, 8'h01, 8'h01, FORM_SEALED, 1'b0,
        '{srcrc_pkg::STATUS_PASS, 17'sd0, 16'h0000}}
   };

   // long division of {payload, init} by the generator, msb first
   function automatic logic [srcrc_pkg::CRC_BITS-1:0] crc7_remainder(
         input logic [srcrc_pkg::PAYLOAD_BITS-1:0] payload);
      logic [srcrc_pkg::WORD_BITS-1:0] acc;
      logic [srcrc_pkg::WORD_BITS-1:0] gen;
      acc = {payload, srcrc_pkg::CRC_INIT};
      gen = '0;
      gen[srcrc_pkg::CRC_BITS:0] = srcrc_pkg::CRC_POLY;
      for (int pos = srcrc_pkg::WORD_BITS - 1; pos >= int'(srcrc_pkg::CRC_BITS); pos--) begin
         if (acc[pos]) begin
            acc ^= gen << (pos - int'(srcrc_pkg::CRC_BITS));
         end
      end
      return acc[srcrc_pkg::CRC_BITS-1:0];
   endfunction

   // check byte with a correct crc for this value and flag
   function automatic logic [7:0] seal_check(input logic [15:0] value, input logic flag);
      return {crc7_remainder({flag, value}), flag};
   endfunction

   // the reading the block owes for one request under the current correction
   function automatic reading_type predict_reading(input readout_type r);
      logic [15:0] t_val;
      logic [15:0] h_val;
      logic        t_crc_ok;
      logic        h_crc_ok;
      reading_type res;
      t_val = {r.t_hi, r.t_lo};
      h_val = {r.h_hi, r.h_lo};
      t_crc_ok = crc7_remainder({r.t_chk[0], t_val}) == r.t_chk[7:1];
      h_crc_ok = crc7_remainder({r.h_chk[0], h_val}) == r.h_chk[7:1];
      res.temperature = '0;
      res.humidity = '0;
      if (!t_crc_ok || !h_crc_ok) begin
         res.status = srcrc_pkg::STATUS_CRC_ERR;
      end else if (!r.t_chk[0] || !r.h_chk[0]) begin
         res.status = srcrc_pkg::STATUS_NOT_VALID;
      end else begin
         res.status = srcrc_pkg::STATUS_PASS;
         res.temperature = {1'b0, t_val} - {9'd0, solder_corr};
         res.humidity = h_val;
      end
      return res;
   endfunction

   // mostly plain values, with extremes and values near the correction
   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h0000;
         1: return 16'hFFFF;
         2: return 16'($urandom_range(0, 511));
         default: return 16'($urandom);
      endcase
   endfunction

   // well-formed readouts dominate; the rest clear flags, break crcs or is noise
   function automatic readout_type random_readout();
      logic [15:0] t_val;
      logic [15:0] h_val;
      logic        t_flag;
      logic        h_flag;
      int unsigned kind;
      readout_type r;
      t_val = pick_value();
      h_val = pick_value();
      kind = $urandom_range(0, 99);
      t_flag = 1'b1;
      h_flag = 1'b1;
      if (kind >= 60 && kind < 75) begin
         // at least one flag clear
         t_flag = 1'($urandom_range(0, 1));
         h_flag = t_flag ? 1'b0 : 1'($urandom_range(0, 1));
      end else if (kind >= 75) begin
         t_flag = 1'($urandom);
         h_flag = 1'($urandom);
      end
      r.t_lo = t_val[7:0];
      r.t_hi = t_val[15:8];
      r.t_chk = seal_check(t_val, t_flag);
      r.h_lo = h_val[7:0];
      r.h_hi = h_val[15:8];
      r.h_chk = seal_check(h_val, h_flag);
      if (kind >= 75 && kind < 90) begin
         case ($urandom_range(0, 2))
            0: r.t_chk ^= CRC_LSB_FLIP << $urandom_range(0, 6);
            1: r.h_chk ^= CRC_LSB_FLIP << $urandom_range(0, 6);
            default: begin
               r.t_chk ^= CRC_LSB_FLIP << $urandom_range(0, 6);
               r.h_chk ^= CRC_LSB_FLIP << $urandom_range(0, 6);
            end
         endcase
      end else if (kind >= 90) begin
         {r.t_lo, r.t_hi, r.t_chk} = 24'($urandom);
         {r.h_lo, r.h_hi, r.h_chk} = 24'($urandom);
      end
      return r;
   endfunction

   // offers one request after a random gap and books its reading on accept
   task automatic send_readout(input readout_type r, input reading_type want);
      int unsigned gap;
      gap = idle_off ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.temp_low_byte    <= r.t_lo;
      req_bus.temp_high_byte   <= r.t_hi;
      req_bus.temp_check_byte  <= r.t_chk;
      req_bus.humid_low_byte   <= r.h_lo;
      req_bus.humid_high_byte  <= r.h_hi;
      req_bus.humid_check_byte <= r.h_chk;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_readings.push_back(want);
   endtask

   // sender pauses until every reading is back, then the register is written
   task automatic drain_and_write(input logic [7:0] corr);
      req_bus.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= corr;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      solder_corr = corr;
      settings_used++;
   endtask

   // 250 mhz clock
   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // overall limit, far above the slowest correct run
   initial begin : run_limit
      #TIMEOUT_NS;
      $display("== FAIL ==");
      $finish;
   end

   // response side: random stalls, one long hold, in-order field checks
   initial begin : response_checker
      int unsigned stall;
      bit          long_hold_done;
      reading_type want;
      long_hold_done = 1'b0;
      rsp_bus.ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         // hold off long once, while the sender keeps offering, so the block fills
         if (responses_seen == LONG_HOLD_AT && !long_hold_done) begin
            stall = LONG_HOLD_CYCLES;
            long_hold_done = 1'b1;
         end else begin
            stall = idle_off ? 0 : $urandom_range(0, MAX_GAP);
         end
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (rsp_bus.valid !== 1'b1);
         if (expected_readings.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_bus.status);
            mismatches++;
         end else begin
            want = expected_readings.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               mismatches++;
            end
            if (rsp_bus.temperature !== want.temperature) begin
               $error("temperature: expected %0d, got %0d",
                      want.temperature, rsp_bus.temperature);
               mismatches++;
            end
            if (rsp_bus.humidity !== want.humidity) begin
               $error("humidity: expected %0d, got %0d", want.humidity, rsp_bus.humidity);
               mismatches++;
            end
            case (want.status)
               srcrc_pkg::STATUS_PASS:    ok_seen++;
               srcrc_pkg::STATUS_CRC_ERR: crc_err_seen++;
               default:                   invalid_seen++;
            endcase
         end
         responses_seen++;
      end
   end

   // request side: reset, directed table, random phases, drain, verdict
   initial begin : request_driver
      readout_type r;
      logic [7:0]  phase_corr [PHASES];
      req_bus.valid            <= 1'b0;
      req_bus.temp_low_byte    <= 8'd0;
      req_bus.temp_high_byte   <= 8'd0;
      req_bus.temp_check_byte  <= 8'd0;
      req_bus.humid_low_byte   <= 8'd0;
      req_bus.humid_high_byte  <= 8'd0;
      req_bus.humid_check_byte <= 8'd0;
      csr_wr_en                <= 1'b0;
      csr_wr_data              <= 8'd0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part, first rows rely on the reset correction of zero
      foreach (directed_rows[i]) begin
         if (directed_rows[i].corr != solder_corr) begin
            drain_and_write(directed_rows[i].corr);
         end
         r.t_lo = directed_rows[i].temp[7:0];
         r.t_hi = directed_rows[i].temp[15:8];
         r.h_lo = directed_rows[i].humid[7:0];
         r.h_hi = directed_rows[i].humid[15:8];
         if (directed_rows[i].form == FORM_RAW) begin
            r.t_chk = directed_rows[i].t_chk;
            r.h_chk = directed_rows[i].h_chk;
         end else begin
            r.t_chk = seal_check(directed_rows[i].temp, directed_rows[i].t_chk[0]);
            r.h_chk = seal_check(directed_rows[i].humid, directed_rows[i].h_chk[0]);
         end
         if (directed_rows[i].form == FORM_TEMP_CRC_BAD) begin
            r.t_chk ^= CRC_LSB_FLIP;
         end
         if (directed_rows[i].form == FORM_HUMID_CRC_BAD) begin
            r.h_chk ^= CRC_LSB_FLIP;
         end
         send_readout(r, directed_rows[i].typed ? directed_rows[i].lit : predict_reading(r));
      end

      // random phases, each under its own correction; phase 1 runs with no idling
      phase_corr[0] = 8'd255;
      phase_corr[1] = 8'd0;
      phase_corr[2] = 8'($urandom_range(2, 253));
      phase_corr[3] = 8'd128;
      phase_corr[4] = 8'($urandom);
      for (int p = 0; p < int'(PHASES); p++) begin
         drain_and_write(phase_corr[p]);
         idle_off = (p == 1);
         repeat (PHASE_READOUTS) begin
            r = random_readout();
            send_readout(r, predict_reading(r));
         end
      end
      idle_off = 1'b0;

      // wait for the last readings, then let any stray response show up
      req_bus.valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("checked %0d readings under %0d solder correction settings, 0 and 255 among them",
               responses_seen, settings_used);
      $display("%0d ok, %0d crc errors, %0d not valid, with one long receiver hold-off",
               ok_seen, crc_err_seen, invalid_seen);
      if (mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
